### hdl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and codes for the staircase line point generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

    localparam int COORD_W = 9;
    localparam int COLOR_W = 16;
    localparam int ERR_W   = 11;

    // item kind carried in the mode field
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // line orientation
    localparam logic [1:0] AXIS_GENERAL    = 2'd0;
    localparam logic [1:0] AXIS_VERTICAL   = 2'd1;
    localparam logic [1:0] AXIS_HORIZONTAL = 2'd2;

    typedef struct packed {
        logic                 mode;
        logic [COORD_W-1:0]   start_x;
        logic [COORD_W-1:0]   start_y;
        logic [COORD_W-1:0]   end_x;
        logic [COORD_W-1:0]   end_y;
        logic [COLOR_W-1:0]   color;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]   point_x;
        logic [COORD_W-1:0]   point_y;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 point_valid;
        logic                 last_point;
        logic                 range_error;
    } out_item_t;

    typedef struct packed {
        logic                     active;
        logic [COORD_W-1:0]       cur_x;
        logic [COORD_W-1:0]       cur_y;
        logic [COORD_W-1:0]       tgt_x;
        logic [COORD_W-1:0]       tgt_y;
        logic signed [ERR_W-1:0]  err;
        logic [COORD_W-1:0]       span_x;
        logic [COORD_W-1:0]       span_y;
        logic                     x_dec;
        logic                     y_dec;
        logic [1:0]               axis;
        logic [COLOR_W-1:0]       color;
    } line_state_t;

endpackage

### hdl/staircase_line_point_generator.sv
// ----------------------------------------------------------------------------
// staircase_line_point_generator
// Four-connected line rasterizer: one panel pixel result per input item.
// ----------------------------------------------------------------------------
// Timing: the result of an item is registered and presented in the cycle after its transfer.
// Throughput: one item per cycle while out_ready is high; the single output register
// frees as its result is taken, so input and output may both transfer in the same cycle.
// Reset: clears the line state, the landscape mode bit and the output valid.
// ----------------------------------------------------------------------------
module staircase_line_point_generator
    import slpg_pkg::*;
#(
    parameter int PANEL_X_MAX = 239,
    parameter int PANEL_Y_MAX = 319
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic        landscape_reg;
    line_state_t state_reg;
    line_state_t state_next;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    line_state_t setup;
    logic        setup_ok;
    line_state_t stepped;
    line_state_t emit_src;
    logic        emit;
    logic        last;
    logic        in_xfer;

    slpg_load #(
        .PANEL_X_MAX (PANEL_X_MAX),
        .PANEL_Y_MAX (PANEL_Y_MAX)
    ) u_load (
        .item      (in_data),
        .landscape (landscape_reg),
        .setup     (setup),
        .setup_ok  (setup_ok)
    );

    slpg_walk u_walk (
        .cur (state_reg),
        .nxt (stepped)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        out_data_next = '0;
        emit          = 1'b0;
        emit_src      = state_reg;
        if (in_data.mode == MODE_LOAD)
        begin
            if (setup_ok)
            begin
                emit     = 1'b1;
                emit_src = setup;
            end
            else
            begin
                // rejected load drops any line in progress
                state_next.active         = 1'b0;
                out_data_next.range_error = 1'b1;
            end
        end
        else if (state_reg.active)
        begin
            emit     = 1'b1;
            emit_src = stepped;
        end

        last = (emit_src.cur_x == emit_src.tgt_x) && (emit_src.cur_y == emit_src.tgt_y);
        if (emit)
        begin
            state_next                = emit_src;
            state_next.active         = !last;
            out_data_next.point_x     = emit_src.cur_x;
            out_data_next.point_y     = emit_src.cur_y;
            out_data_next.pixel_color = emit_src.color;
            out_data_next.point_valid = 1'b1;
            out_data_next.last_point  = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landscape_reg <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                landscape_reg <= cfg_wdata;
            if (in_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/slpg_load.sv
// ----------------------------------------------------------------------------
// slpg_load
// Maps both endpoints to panel space, checks range, and sets up the walk.
// ----------------------------------------------------------------------------
module slpg_load
    import slpg_pkg::*;
#(
    parameter int PANEL_X_MAX = 239,
    parameter int PANEL_Y_MAX = 319
)
(
    input  in_item_t    item,
    input  logic        landscape,
    output line_state_t setup,
    output logic        setup_ok
);

    localparam logic [COORD_W-1:0] XMAX = COORD_W'(PANEL_X_MAX);
    localparam logic [COORD_W-1:0] YMAX = COORD_W'(PANEL_Y_MAX);

    logic [COORD_W-1:0] x1, y1, x2, y2;
    logic               ok1, ok2;

    always_comb
    begin
        if (landscape)
        begin
            // a logical y past the panel width would wrap in the subtraction
            ok1 = (item.start_y <= XMAX) && (item.start_x <= YMAX);
            ok2 = (item.end_y <= XMAX) && (item.end_x <= YMAX);
            x1  = XMAX - item.start_y;
            y1  = item.start_x;
            x2  = XMAX - item.end_y;
            y2  = item.end_x;
        end
        else
        begin
            ok1 = (item.start_x <= XMAX) && (item.start_y <= YMAX);
            ok2 = (item.end_x <= XMAX) && (item.end_y <= YMAX);
            x1  = item.start_x;
            y1  = item.start_y;
            x2  = item.end_x;
            y2  = item.end_y;
        end
    end

    assign setup_ok = ok1 && ok2;

    always_comb
    begin
        setup        = '0;
        setup.active = 1'b1;
        setup.color  = item.color;
        setup.err    = '0;
        if (x1 == x2)
        begin
            setup.axis  = AXIS_VERTICAL;
            setup.cur_x = x1;
            setup.tgt_x = x1;
            setup.cur_y = (y1 <= y2) ? y1 : y2;
            setup.tgt_y = (y1 <= y2) ? y2 : y1;
            setup.span_y = setup.tgt_y - setup.cur_y;
        end
        else if (y1 == y2)
        begin
            setup.axis  = AXIS_HORIZONTAL;
            setup.cur_y = y1;
            setup.tgt_y = y1;
            setup.cur_x = (x1 <= x2) ? x1 : x2;
            setup.tgt_x = (x1 <= x2) ? x2 : x1;
            setup.span_x = setup.tgt_x - setup.cur_x;
        end
        else
        begin
            setup.axis   = AXIS_GENERAL;
            setup.cur_x  = x1;
            setup.cur_y  = y1;
            setup.tgt_x  = x2;
            setup.tgt_y  = y2;
            setup.span_x = (x2 > x1) ? x2 - x1 : x1 - x2;
            setup.span_y = (y2 > y1) ? y2 - y1 : y1 - y2;
            setup.x_dec  = (x2 < x1);
            setup.y_dec  = (y2 < y1);
        end
    end

endmodule

### hdl/slpg_walk.sv
// ----------------------------------------------------------------------------
// slpg_walk
// One staircase step: moves the current point and, for a general line, updates the error term.
// ----------------------------------------------------------------------------
module slpg_walk
    import slpg_pkg::*;
(
    input  line_state_t cur,
    output line_state_t nxt
);

    logic signed [ERR_W:0] err_wide;
    logic signed [ERR_W:0] err_sum;

    assign err_wide = {cur.err[ERR_W-1], cur.err};

    always_comb
    begin
        nxt     = cur;
        err_sum = err_wide;
        case (cur.axis)
            AXIS_VERTICAL:
            begin
                nxt.cur_y = cur.cur_y + COORD_W'(1);
            end
            AXIS_HORIZONTAL:
            begin
                nxt.cur_x = cur.cur_x + COORD_W'(1);
            end
            default:
            begin
                if (!cur.err[ERR_W-1])
                begin
                    nxt.cur_x = cur.x_dec ? cur.cur_x - COORD_W'(1)
                                          : cur.cur_x + COORD_W'(1);
                    err_sum   = err_wide - $signed({3'b000, cur.span_y});
                end
                else
                begin
                    nxt.cur_y = cur.y_dec ? cur.cur_y - COORD_W'(1)
                                          : cur.cur_y + COORD_W'(1);
                    err_sum   = err_wide + $signed({3'b000, cur.span_x});
                end
            end
        endcase
        // saturate to the 11-bit signed range
        if (err_sum[ERR_W] != err_sum[ERR_W-1])
            nxt.err = err_sum[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                     : {1'b0, {(ERR_W-1){1'b1}}};
        else
            nxt.err = err_sum[ERR_W-1:0];
    end

endmodule
